@@ rtl/core/ats_pkg.sv @@
// ----------------------------------------------------------------------------
// ats_pkg - shared types for the aging two-level scheduler
// Request and response words, action and status codes, controller states and
// the command groups sent to the task and thread cells.
// ----------------------------------------------------------------------------
package ats_pkg;

   typedef enum logic [1:0] {
      ACT_TICK          = 2'd0,
      ACT_CREATE_TASK   = 2'd1,
      ACT_CREATE_THREAD = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STS_SWITCHED  = 2'd0,
      STS_NO_SWITCH = 2'd1,
      STS_CREATED   = 2'd2,
      STS_REJECTED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SCH_IDLE,
      SCH_TASK_SWEEP,
      SCH_THREAD_INJ,
      SCH_THREAD_SWEEP,
      SCH_COMMIT_OLD,
      SCH_COMMIT_NEW
   } sched_state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] task_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] task_id;
      logic [1:0] thread_id;
   } rsp_type;

   // commands broadcast to every task cell
   typedef struct packed {
      logic create;
      logic add_thread;
      logic commit;
   } tcell_cmd_type;

   // commands broadcast to every thread cell
   typedef struct packed {
      logic rd;
      logic create;
      logic clear_old;
      logic set_new;
   } thcell_cmd_type;

endpackage

@@ rtl/core/aging_two_level_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// aging_two_level_scheduler_top - oldest-waiting-first task/thread scheduler
// Picks the longest-idle waiting task, then its longest-idle waiting thread.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a word on req_word is taken at a rising edge with start
//   high and busy low. Actions: scheduling tick, create task, create thread.
//   Response channel: every request gives exactly one word on rsp_word,
//   marked by rsp_valid for one cycle. The receiver cannot stall; the word is
//   taken at the edge ending that cycle.
//   Create task / create thread: the response is registered and comes in the
//   next cycle, busy stays low, so one create word can be taken every cycle.
//   Tick: a best-so-far token walks the task cells, one cell a cycle, then
//   the chosen task's slot is read from every thread cell and a token walks
//   the thread cells, then the commit states COMMIT_OLD and COMMIT_NEW. The
//   response is registered in COMMIT_NEW, or where a walk finds nothing to
//   run; the next request is taken in the cycle of the response strobe.
//   Reset (synchronous, high): no tasks, nothing running, no response pending.
//   Thread slot storage needs no clearing: a slot is written when created.
// ----------------------------------------------------------------------------
module aging_two_level_scheduler_top #(
   parameter int MAX_TASKS   = 8,
   parameter int MAX_THREADS = 4,
   parameter int IDLE_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ats_pkg::req_type req_word,
   output logic             rsp_valid,
   output ats_pkg::rsp_type rsp_word
);

   localparam int TIW  = $clog2(MAX_TASKS);
   localparam int TCW  = $clog2(MAX_TASKS + 1);
   localparam int TTW  = $clog2(MAX_THREADS + 1);
   localparam int SW   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CMPW = (TCW > 3) ? TCW : 3;

   localparam logic [TCW-1:0] TASK_FULL = TCW'(MAX_TASKS);
   localparam logic [TTW-1:0] THR_FULL  = TTW'(MAX_THREADS);

   // controller registers
   ats_pkg::sched_state_type state_ff, state_in;
   logic [TCW-1:0]   task_total_ff, task_total_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [TIW-1:0]   cur_task_ff, cur_task_in;
   logic [SW-1:0]    cur_thread_ff, cur_thread_in;
   logic [TIW-1:0]   nt_ff, nt_in;        // chosen task
   logic [TTW-1:0]   ntot_ff, ntot_in;    // its thread total
   logic [SW-1:0]    ns_ff, ns_in;        // chosen thread slot
   logic             rsp_valid_ff, rsp_valid_in;
   ats_pkg::rsp_type rsp_word_ff, rsp_word_in;

   // cell commands
   ats_pkg::tcell_cmd_type  tcmd;
   ats_pkg::thcell_cmd_type thcmd;
   logic [TIW-1:0]          sel_idx;
   logic [TIW-1:0]          th_addr;
   logic [SW-1:0]           th_sel_slot;
   logic                    tk_inject;   // token into the task chain
   logic                    th_inject;   // token into the thread chain

   // task chain: entry i feeds cell i, entry MAX_TASKS is the tail
   logic                 tk_valid   [MAX_TASKS+1];
   logic                 tk_found   [MAX_TASKS+1];
   logic [IDLE_BITS-1:0] tk_best    [MAX_TASKS+1];
   logic [TIW-1:0]       tk_idx     [MAX_TASKS+1];
   logic [TTW-1:0]       tk_tot     [MAX_TASKS+1];
   logic [TTW-1:0]       tk_cur_tot [MAX_TASKS+1];
   logic [TTW-1:0]       thr_total_all [MAX_TASKS];

   // thread chain
   logic                 th_valid [MAX_THREADS+1];
   logic                 th_found [MAX_THREADS+1];
   logic [IDLE_BITS-1:0] th_best  [MAX_THREADS+1];
   logic [SW-1:0]        th_slot  [MAX_THREADS+1];

   logic                 accept;
   logic [TIW-1:0]       t_ext;
   logic                 t_ok;
   logic [TTW-1:0]       tot_t;
   logic                 same_pair;

   assign accept = start && (state_ff == ats_pkg::SCH_IDLE);
   assign busy   = (state_ff != ats_pkg::SCH_IDLE);
   assign t_ext  = TIW'(req_word.task_index);
   // a present task index is always below MAX_TASKS
   assign t_ok   = CMPW'(req_word.task_index) < CMPW'(task_total_ff);
   assign tot_t  = thr_total_all[t_ext];
   assign same_pair = cur_valid_ff && (nt_ff == cur_task_ff) && (ns_ff == cur_thread_ff);

   // chain heads
   assign tk_valid[0]   = tk_inject;
   assign tk_found[0]   = 1'b0;
   assign tk_best[0]    = '0;
   assign tk_idx[0]     = '0;
   assign tk_tot[0]     = '0;
   assign tk_cur_tot[0] = '0;
   assign th_valid[0]   = th_inject;
   assign th_found[0]   = 1'b0;
   assign th_best[0]    = '0;
   assign th_slot[0]    = '0;

   always_comb begin
      state_in      = state_ff;
      task_total_in = task_total_ff;
      cur_valid_in  = cur_valid_ff;
      cur_task_in   = cur_task_ff;
      cur_thread_in = cur_thread_ff;
      nt_in         = nt_ff;
      ntot_in       = ntot_ff;
      ns_in         = ns_ff;
      rsp_valid_in  = 1'b0;
      rsp_word_in   = rsp_word_ff;
      tcmd          = '0;
      thcmd         = '0;
      sel_idx       = nt_ff;
      th_addr       = nt_ff;
      th_sel_slot   = ns_ff;
      tk_inject     = 1'b0;
      th_inject     = 1'b0;

      unique case (state_ff)
         ats_pkg::SCH_IDLE: begin
            if (accept) begin
               rsp_word_in.status    = ats_pkg::STS_REJECTED;
               rsp_word_in.task_id   = '0;
               rsp_word_in.thread_id = '0;
               unique case (req_word.action)
                  ats_pkg::ACT_TICK: begin
                     tk_inject = 1'b1;
                     state_in  = ats_pkg::SCH_TASK_SWEEP;
                  end
                  ats_pkg::ACT_CREATE_TASK: begin
                     rsp_valid_in = 1'b1;
                     if (task_total_ff != TASK_FULL) begin
                        tcmd.create         = 1'b1;
                        sel_idx             = TIW'(task_total_ff);
                        task_total_in       = task_total_ff + 1'b1;
                        rsp_word_in.status  = ats_pkg::STS_CREATED;
                        rsp_word_in.task_id = 3'(task_total_ff);
                     end
                  end
                  ats_pkg::ACT_CREATE_THREAD: begin
                     rsp_valid_in = 1'b1;
                     if (t_ok && tot_t != THR_FULL) begin
                        tcmd.add_thread       = 1'b1;
                        sel_idx               = t_ext;
                        thcmd.create          = 1'b1;
                        th_addr               = t_ext;
                        th_sel_slot           = SW'(tot_t);
                        rsp_word_in.status    = ats_pkg::STS_CREATED;
                        rsp_word_in.task_id   = req_word.task_index;
                        rsp_word_in.thread_id = 2'(tot_t);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ats_pkg::SCH_TASK_SWEEP: begin
            if (tk_valid[MAX_TASKS]) begin
               if (tk_found[MAX_TASKS]) begin
                  nt_in     = tk_idx[MAX_TASKS];
                  ntot_in   = tk_tot[MAX_TASKS];
                  thcmd.rd  = 1'b1;
                  state_in  = ats_pkg::SCH_THREAD_INJ;
               end else if (cur_valid_ff) begin
                  // nothing waiting: the running task is chosen again
                  nt_in     = cur_task_ff;
                  ntot_in   = tk_cur_tot[MAX_TASKS];
                  thcmd.rd  = 1'b1;
                  state_in  = ats_pkg::SCH_THREAD_INJ;
               end else begin
                  rsp_valid_in          = 1'b1;
                  rsp_word_in.status    = ats_pkg::STS_NO_SWITCH;
                  rsp_word_in.task_id   = '0;
                  rsp_word_in.thread_id = '0;
                  state_in              = ats_pkg::SCH_IDLE;
               end
            end
            th_addr = nt_in;
         end

         ats_pkg::SCH_THREAD_INJ: begin
            th_inject = 1'b1;
            state_in  = ats_pkg::SCH_THREAD_SWEEP;
         end

         ats_pkg::SCH_THREAD_SWEEP: begin
            if (th_valid[MAX_THREADS]) begin
               if (th_found[MAX_THREADS]) begin
                  ns_in    = th_slot[MAX_THREADS];
                  state_in = ats_pkg::SCH_COMMIT_OLD;
               end else if (cur_valid_ff && nt_ff == cur_task_ff) begin
                  ns_in    = cur_thread_ff;
                  state_in = ats_pkg::SCH_COMMIT_OLD;
               end else begin
                  // no runnable thread: report the current pair (zero when none)
                  rsp_valid_in          = 1'b1;
                  rsp_word_in.status    = ats_pkg::STS_NO_SWITCH;
                  rsp_word_in.task_id   = 3'(cur_task_ff);
                  rsp_word_in.thread_id = 2'(cur_thread_ff);
                  state_in              = ats_pkg::SCH_IDLE;
               end
            end
         end

         ats_pkg::SCH_COMMIT_OLD: begin
            thcmd.clear_old = cur_valid_ff;
            state_in        = ats_pkg::SCH_COMMIT_NEW;
         end

         ats_pkg::SCH_COMMIT_NEW: begin
            thcmd.set_new         = 1'b1;
            tcmd.commit           = 1'b1;
            rsp_valid_in          = 1'b1;
            rsp_word_in.status    = same_pair ? ats_pkg::STS_NO_SWITCH : ats_pkg::STS_SWITCHED;
            rsp_word_in.task_id   = 3'(nt_ff);
            rsp_word_in.thread_id = 2'(ns_ff);
            cur_valid_in          = 1'b1;
            cur_task_in           = nt_ff;
            cur_thread_in         = ns_ff;
            state_in              = ats_pkg::SCH_IDLE;
         end

         default: begin
            state_in = ats_pkg::SCH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ats_pkg::SCH_IDLE;
         task_total_ff <= '0;
         cur_valid_ff  <= 1'b0;
         cur_task_ff   <= '0;
         cur_thread_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_total_ff <= task_total_in;
         cur_valid_ff  <= cur_valid_in;
         cur_task_ff   <= cur_task_in;
         cur_thread_ff <= cur_thread_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nt_ff       <= nt_in;
      ntot_ff     <= ntot_in;
      ns_ff       <= ns_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // task cells
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_task
      ats_task_cell #(
         .IDX       (i),
         .TIW       (TIW),
         .TTW       (TTW),
         .IDLE_BITS (IDLE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (tcmd),
         .sel_idx      (sel_idx),
         .cur_idx      (cur_task_ff),
         .cur_valid    (cur_valid_ff),
         .tin_valid    (tk_valid[i]),
         .tin_found    (tk_found[i]),
         .tin_best     (tk_best[i]),
         .tin_idx      (tk_idx[i]),
         .tin_tot      (tk_tot[i]),
         .tin_cur_tot  (tk_cur_tot[i]),
         .tout_valid   (tk_valid[i+1]),
         .tout_found   (tk_found[i+1]),
         .tout_best    (tk_best[i+1]),
         .tout_idx     (tk_idx[i+1]),
         .tout_tot     (tk_tot[i+1]),
         .tout_cur_tot (tk_cur_tot[i+1]),
         .thr_total    (thr_total_all[i])
      );
   end

   // thread cells, one per slot
   for (genvar s = 0; s < MAX_THREADS; s++) begin : g_thread
      ats_thread_cell #(
         .IDX       (s),
         .MAX_TASKS (MAX_TASKS),
         .TIW       (TIW),
         .TTW       (TTW),
         .SW        (SW),
         .IDLE_BITS (IDLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (thcmd),
         .addr       (th_addr),
         .old_addr   (cur_task_ff),
         .sel_slot   (th_sel_slot),
         .cur_slot   (cur_thread_ff),
         .tot        (ntot_ff),
         .tin_valid  (th_valid[s]),
         .tin_found  (th_found[s]),
         .tin_best   (th_best[s]),
         .tin_slot   (th_slot[s]),
         .tout_valid (th_valid[s+1]),
         .tout_found (th_found[s+1]),
         .tout_best  (th_best[s+1]),
         .tout_slot  (th_slot[s+1])
      );
   end

`ifndef ASSERT_OFF
   // the response strobe always lands with the controller back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // creates and rejects answer on the next cycle
   a_create_lat: assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.action != ats_pkg::ACT_TICK) |=> rsp_valid)
      else $error("create word not answered in one cycle");

   a_task_count: assert property (@(posedge clock) disable iff (reset)
      task_total_ff <= TASK_FULL)
      else $error("task count beyond table");

   // the running task always exists
   a_cur_live: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (TCW'(cur_task_ff) < task_total_ff))
      else $error("running task not present");
`endif

endmodule

@@ rtl/core/ats_task_cell.sv @@
// ----------------------------------------------------------------------------
// ats_task_cell - one task of the task chain
// Holds the idle count, running mark and thread total of one task; ages the
// task and updates the best-so-far token as it passes.
// ----------------------------------------------------------------------------
module ats_task_cell #(
   parameter int IDX       = 0,
   parameter int TIW       = 3,
   parameter int TTW       = 3,
   parameter int IDLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ats_pkg::tcell_cmd_type    cmd,
   input  logic [TIW-1:0]            sel_idx,
   input  logic [TIW-1:0]            cur_idx,
   input  logic                      cur_valid,
   input  logic                      tin_valid,
   input  logic                      tin_found,
   input  logic [IDLE_BITS-1:0]      tin_best,
   input  logic [TIW-1:0]            tin_idx,
   input  logic [TTW-1:0]            tin_tot,
   input  logic [TTW-1:0]            tin_cur_tot,
   output logic                      tout_valid,
   output logic                      tout_found,
   output logic [IDLE_BITS-1:0]      tout_best,
   output logic [TIW-1:0]            tout_idx,
   output logic [TTW-1:0]            tout_tot,
   output logic [TTW-1:0]            tout_cur_tot,
   output logic [TTW-1:0]            thr_total
);

   localparam logic [TIW-1:0]       MY_IDX   = TIW'(IDX);
   localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;

   logic                 live_ff, live_in;
   logic                 busy_ff, busy_in;
   logic [IDLE_BITS-1:0] idle_ff, idle_in;
   logic [TTW-1:0]       tot_ff, tot_in;

   logic                 tok_valid_ff, tok_found_ff, tok_found_in;
   logic [IDLE_BITS-1:0] tok_best_ff, tok_best_in;
   logic [TIW-1:0]       tok_idx_ff, tok_idx_in;
   logic [TTW-1:0]       tok_tot_ff, tok_tot_in;
   logic [TTW-1:0]       tok_cur_tot_ff, tok_cur_tot_in;

   logic                 is_sel, is_cur, cand;
   logic [IDLE_BITS-1:0] bumped;

   assign is_sel = (sel_idx == MY_IDX);
   assign is_cur = cur_valid && (cur_idx == MY_IDX);
   assign bumped = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 1'b1;
   // strict compare: an earlier cell keeps a tie
   assign cand   = tin_valid && live_ff && !busy_ff && (!tin_found || bumped > tin_best);

   always_comb begin
      live_in = live_ff;
      busy_in = busy_ff;
      idle_in = idle_ff;
      tot_in  = tot_ff;
      if (tin_valid && live_ff) begin
         idle_in = bumped;
      end
      if (cmd.create && is_sel) begin
         live_in = 1'b1;
         busy_in = 1'b0;
         idle_in = '0;
         tot_in  = '0;
      end
      if (cmd.add_thread && is_sel) begin
         tot_in = tot_ff + 1'b1;
      end
      if (cmd.commit) begin
         if (is_cur) begin
            busy_in = 1'b0;
         end
         if (is_sel) begin
            busy_in = 1'b1;
            idle_in = '0;
         end
      end
   end

   always_comb begin
      tok_found_in   = tin_found || cand;
      tok_best_in    = cand ? bumped : tin_best;
      tok_idx_in     = cand ? MY_IDX : tin_idx;
      tok_tot_in     = cand ? tot_ff : tin_tot;
      tok_cur_tot_in = is_cur ? tot_ff : tin_cur_tot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         live_ff      <= live_in;
         busy_ff      <= busy_in;
         tok_valid_ff <= tin_valid;
      end
   end

   always_ff @(posedge clock) begin
      idle_ff        <= idle_in;
      tot_ff         <= tot_in;
      tok_found_ff   <= tok_found_in;
      tok_best_ff    <= tok_best_in;
      tok_idx_ff     <= tok_idx_in;
      tok_tot_ff     <= tok_tot_in;
      tok_cur_tot_ff <= tok_cur_tot_in;
   end

   assign tout_valid   = tok_valid_ff;
   assign tout_found   = tok_found_ff;
   assign tout_best    = tok_best_ff;
   assign tout_idx     = tok_idx_ff;
   assign tout_tot     = tok_tot_ff;
   assign tout_cur_tot = tok_cur_tot_ff;
   assign thr_total    = tot_ff;

endmodule

@@ rtl/core/ats_thread_cell.sv @@
// ----------------------------------------------------------------------------
// ats_thread_cell - one thread slot of the thread chain
// Holds this slot's idle count and running mark for every task in a small
// memory; ages the chosen task's slot as the token passes.
// ----------------------------------------------------------------------------
module ats_thread_cell #(
   parameter int IDX       = 0,
   parameter int MAX_TASKS = 8,
   parameter int TIW       = 3,
   parameter int TTW       = 3,
   parameter int SW        = 2,
   parameter int IDLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ats_pkg::thcell_cmd_type   cmd,
   input  logic [TIW-1:0]            addr,
   input  logic [TIW-1:0]            old_addr,
   input  logic [SW-1:0]             sel_slot,
   input  logic [SW-1:0]             cur_slot,
   input  logic [TTW-1:0]            tot,
   input  logic                      tin_valid,
   input  logic                      tin_found,
   input  logic [IDLE_BITS-1:0]      tin_best,
   input  logic [SW-1:0]             tin_slot,
   output logic                      tout_valid,
   output logic                      tout_found,
   output logic [IDLE_BITS-1:0]      tout_best,
   output logic [SW-1:0]             tout_slot
);

   localparam logic [SW-1:0]        MY_SLOT  = SW'(IDX);
   localparam logic [TTW-1:0]       MY_CNT   = TTW'(IDX);
   localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;

   logic [IDLE_BITS-1:0] idle_mem [MAX_TASKS];
   logic                 busy_mem [MAX_TASKS];

   logic [IDLE_BITS-1:0] idle_rd_ff;
   logic                 busy_rd_ff;

   logic                 idle_we, busy_we, busy_wd;
   logic [IDLE_BITS-1:0] idle_wd;
   logic [TIW-1:0]       busy_wa;

   logic                 tok_valid_ff, tok_found_ff, tok_found_in;
   logic [IDLE_BITS-1:0] tok_best_ff, tok_best_in;
   logic [SW-1:0]        tok_slot_ff, tok_slot_in;

   logic                 exists, cand;
   logic [IDLE_BITS-1:0] bumped;

   assign exists = (MY_CNT < tot);
   assign bumped = (idle_rd_ff == IDLE_MAX) ? idle_rd_ff : idle_rd_ff + 1'b1;
   assign cand   = tin_valid && exists && !busy_rd_ff && (!tin_found || bumped > tin_best);

   // one write per memory per cycle; the sources never overlap in time
   always_comb begin
      idle_we = 1'b0;
      idle_wd = '0;
      busy_we = 1'b0;
      busy_wd = 1'b0;
      busy_wa = addr;
      if (cmd.create && sel_slot == MY_SLOT) begin
         idle_we = 1'b1;
         busy_we = 1'b1;
      end
      if (tin_valid && exists) begin
         idle_we = 1'b1;
         idle_wd = bumped;
      end
      if (cmd.clear_old && cur_slot == MY_SLOT) begin
         busy_we = 1'b1;
         busy_wa = old_addr;
      end
      if (cmd.set_new && sel_slot == MY_SLOT) begin
         idle_we = 1'b1;
         busy_we = 1'b1;
         busy_wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (idle_we) begin
         idle_mem[addr] <= idle_wd;
      end
      if (cmd.rd) begin
         idle_rd_ff <= idle_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (busy_we) begin
         busy_mem[busy_wa] <= busy_wd;
      end
      if (cmd.rd) begin
         busy_rd_ff <= busy_mem[addr];
      end
   end

   always_comb begin
      tok_found_in = tin_found || cand;
      tok_best_in  = cand ? bumped : tin_best;
      tok_slot_in  = cand ? MY_SLOT : tin_slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tin_valid;
      end
   end

   always_ff @(posedge clock) begin
      tok_found_ff <= tok_found_in;
      tok_best_ff  <= tok_best_in;
      tok_slot_ff  <= tok_slot_in;
   end

   assign tout_valid = tok_valid_ff;
   assign tout_found = tok_found_ff;
   assign tout_best  = tok_best_ff;
   assign tout_slot  = tok_slot_ff;

endmodule

@@ tb/aging_two_level_scheduler_top_tb.sv @@
// ----------------------------------------------------------------------------
// aging_two_level_scheduler_top_tb - self-checking bench for the scheduler
// Drives create-task, create-thread, tick and unknown words in bursts, keeps
// its own copy of the task and thread tables to predict every response word,
// and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module aging_two_level_scheduler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_TASKS   = 8;
   localparam int MAX_THREADS = 4;
   localparam int IDLE_BITS   = 16;

   // action code the block does not know; must come back rejected
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   localparam int RANDOM_WORDS = 1300;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PRINT_CAP    = 100;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   ats_pkg::req_type req_word;
   logic             rsp_valid;
   ats_pkg::rsp_type rsp_word;

   aging_two_level_scheduler_top #(
      .MAX_TASKS  (MAX_TASKS),
      .MAX_THREADS(MAX_THREADS),
      .IDLE_BITS  (IDLE_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word)
   );

   // 4 ns period
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Scheduler shadow: task and thread tables as the block should hold them
   // -------------------------------------------------------------------------
   logic [3:0]           task_cnt;
   logic [IDLE_BITS-1:0] task_age     [MAX_TASKS];
   logic                 task_running [MAX_TASKS];
   logic [2:0]           slot_cnt     [MAX_TASKS];
   logic [IDLE_BITS-1:0] slot_age     [MAX_TASKS][MAX_THREADS];
   logic                 slot_running [MAX_TASKS][MAX_THREADS];
   logic                 cur_valid;
   logic [2:0]           cur_task;
   logic [1:0]           cur_slot;

   // response words still owed by the block, oldest first
   ats_pkg::rsp_type awaited_words[$];

   int fault_count;
   int cycle_count;
   int burst_left;

   // ageing saturates at all ones
   function automatic logic [IDLE_BITS-1:0] aged(input logic [IDLE_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Applies one accepted word to the shadow tables, returns the reply.
   function automatic ats_pkg::rsp_type schedule_step(input ats_pkg::req_type w);
      ats_pkg::rsp_type     r;
      logic [IDLE_BITS-1:0] best;
      logic                 found;
      logic [2:0]           pick_task;
      logic [1:0]           pick_slot;
      logic                 same;
      int                   t;
      int                   i;

      r         = '0;
      r.status  = ats_pkg::STS_REJECTED;
      pick_task = '0;
      pick_slot = '0;
      t         = w.task_index;

      unique case (w.action)
         ats_pkg::ACT_CREATE_TASK: begin
            if (task_cnt < MAX_TASKS) begin
               task_age[task_cnt]     = '0;
               task_running[task_cnt] = 1'b0;
               slot_cnt[task_cnt]     = '0;
               for (i = 0; i < MAX_THREADS; i++) begin
                  slot_age[task_cnt][i]     = '0;
                  slot_running[task_cnt][i] = 1'b0;
               end
               r.status  = ats_pkg::STS_CREATED;
               r.task_id = task_cnt[2:0];
               task_cnt  = task_cnt + 1'b1;
            end
         end

         ats_pkg::ACT_CREATE_THREAD: begin
            // absent task or all slots taken: rejected, tables untouched
            if (t < task_cnt && slot_cnt[t] < MAX_THREADS) begin
               slot_age[t][slot_cnt[t]]     = '0;
               slot_running[t][slot_cnt[t]] = 1'b0;
               r.status    = ats_pkg::STS_CREATED;
               r.task_id   = w.task_index;
               r.thread_id = slot_cnt[t][1:0];
               slot_cnt[t] = slot_cnt[t] + 1'b1;
            end
         end

         ats_pkg::ACT_TICK: begin
            // task level: every task ages, oldest waiting one wins, lowest index on ties
            found = 1'b0;
            best  = '0;
            for (i = 0; i < task_cnt; i++) begin
               task_age[i] = aged(task_age[i]);
               if (!task_running[i] && (!found || task_age[i] > best)) begin
                  best      = task_age[i];
                  pick_task = 3'(i);
                  found     = 1'b1;
               end
            end
            r.status = ats_pkg::STS_NO_SWITCH;
            if (!found) begin
               // nothing waiting: stay on the current task, or nothing at all
               if (!cur_valid)
                  return r;
               pick_task = cur_task;
            end

            // thread level, only within the chosen task
            found = 1'b0;
            best  = '0;
            for (i = 0; i < slot_cnt[pick_task]; i++) begin
               slot_age[pick_task][i] = aged(slot_age[pick_task][i]);
               if (!slot_running[pick_task][i] &&
                   (!found || slot_age[pick_task][i] > best)) begin
                  best      = slot_age[pick_task][i];
                  pick_slot = 2'(i);
                  found     = 1'b1;
               end
            end
            if (!found) begin
               if (cur_valid && pick_task == cur_task) begin
                  pick_slot = cur_slot;
               end else begin
                  // threadless task picked: report what is running, marks unchanged
                  if (cur_valid) begin
                     r.task_id   = cur_task;
                     r.thread_id = cur_slot;
                  end
                  return r;
               end
            end

            same = cur_valid && pick_task == cur_task && pick_slot == cur_slot;
            if (cur_valid) begin
               task_running[cur_task]           = 1'b0;
               slot_running[cur_task][cur_slot] = 1'b0;
            end
            task_age[pick_task]                = '0;
            slot_age[pick_task][pick_slot]     = '0;
            task_running[pick_task]            = 1'b1;
            slot_running[pick_task][pick_slot] = 1'b1;
            cur_valid   = 1'b1;
            cur_task    = pick_task;
            cur_slot    = pick_slot;
            r.status    = same ? ats_pkg::STS_NO_SWITCH : ats_pkg::STS_SWITCHED;
            r.task_id   = pick_task;
            r.thread_id = pick_slot;
         end

         default: ;  // unknown action: rejected, nothing changes
      endcase
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Reporting
   // -------------------------------------------------------------------------
   task automatic report_fault(input string what);
      if (fault_count < PRINT_CAP)
         $display("[%0d] error: %s", cycle_count, what);
      fault_count++;
   endtask

   // -------------------------------------------------------------------------
   // Sender: one word per call, bursts of random length with random gaps.
   // start is left high after acceptance so back-to-back words never lower
   // and raise it within one time step; a gap lowers it at the next falling
   // edge instead.
   // -------------------------------------------------------------------------
   task automatic send_word(input logic [1:0] act, input logic [2:0] idx);
      ats_pkg::req_type w;
      int               gap;

      w.action     = act;
      w.task_index = idx;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      // taken at the first rising edge that sees busy low
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_words.push_back(schedule_step(w));
      burst_left--;
   endtask

   // -------------------------------------------------------------------------
   // Response checker: the receiver never stalls, every strobe is a word
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      ats_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_words.size() == 0) begin
            report_fault($sformatf("unexpected response %0d/%0d/%0d",
                                   rsp_word.status, rsp_word.task_id, rsp_word.thread_id));
         end else begin
            want = awaited_words.pop_front();
            if (rsp_word.status !== want.status)
               report_fault($sformatf("status %0d, wanted %0d",
                                      rsp_word.status, want.status));
            if (rsp_word.task_id !== want.task_id)
               report_fault($sformatf("task_id %0d, wanted %0d",
                                      rsp_word.task_id, want.task_id));
            if (rsp_word.thread_id !== want.thread_id)
               report_fault($sformatf("thread_id %0d, wanted %0d",
                                      rsp_word.thread_id, want.thread_id));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Nothing exists yet: tick gives no switch, creates of threads and the
   // unknown action are rejected. Extremes of task_index on both.
   task automatic test_empty_tables();
      send_word(ats_pkg::ACT_TICK, 3'd0);
      send_word(ats_pkg::ACT_CREATE_THREAD, 3'd0);
      send_word(ats_pkg::ACT_CREATE_THREAD, 3'd7);
      send_word(ACT_UNKNOWN, 3'd7);
      send_word(ACT_UNKNOWN, 3'd0);
   endtask

   // One task only, so nothing else is ever waiting: covers the threadless
   // task, the same pair chosen again, and switching between its own threads.
   task automatic test_single_task();
      send_word(ats_pkg::ACT_CREATE_TASK, 3'd5);
      send_word(ats_pkg::ACT_TICK, 3'd0);           // task without threads, nothing running
      send_word(ats_pkg::ACT_CREATE_THREAD, 3'd0);
      send_word(ats_pkg::ACT_TICK, 3'd0);           // first switch
      send_word(ats_pkg::ACT_TICK, 3'd0);           // same pair again
      send_word(ats_pkg::ACT_CREATE_THREAD, 3'd0);
      send_word(ats_pkg::ACT_TICK, 3'd0);           // to the second thread
      send_word(ats_pkg::ACT_TICK, 3'd7);           // and back
      send_word(ats_pkg::ACT_TICK, 3'd0);
   endtask

   // A second, threadless task wins the task level while a pair is running.
   task automatic test_threadless_rival();
      send_word(ats_pkg::ACT_CREATE_TASK, 3'd0);
      send_word(ats_pkg::ACT_TICK, 3'd0);
      send_word(ats_pkg::ACT_CREATE_THREAD, 3'd1);
      send_word(ats_pkg::ACT_CREATE_THREAD, 3'd2);  // absent task
      send_word(ats_pkg::ACT_TICK, 3'd0);
      send_word(ats_pkg::ACT_TICK, 3'd0);
   endtask

   // Mostly ticks so the ages spread out, with creates mixed in until the
   // tables fill, plus stray thread creates and unknown actions.
   task automatic test_random_mix();
      logic [1:0] act;
      logic [2:0] idx;
      int         sel;

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 58)      act = ats_pkg::ACT_TICK;
         else if (sel < 68) act = ats_pkg::ACT_CREATE_TASK;
         else if (sel < 94) act = ats_pkg::ACT_CREATE_THREAD;
         else               act = ACT_UNKNOWN;
         if (act == ats_pkg::ACT_CREATE_THREAD && task_cnt != 0 && $urandom_range(0, 4) != 0)
            idx = 3'($urandom_range(0, task_cnt - 1));
         else
            idx = 3'($urandom_range(0, 7));
         send_word(act, idx);
      end
   endtask

   // Fill every table to the brim and push past it, then a few ticks.
   task automatic test_full_tables();
      for (int n = 0; n <= MAX_TASKS; n++)
         send_word(ats_pkg::ACT_CREATE_TASK, 3'($urandom_range(0, 7)));
      for (int t = 0; t < MAX_TASKS; t++)
         for (int s = 0; s <= MAX_THREADS; s++)
            send_word(ats_pkg::ACT_CREATE_THREAD, 3'(t));
      repeat (12) send_word(ats_pkg::ACT_TICK, 3'($urandom_range(0, 7)));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_word     = '0;
      fault_count  = 0;
      cycle_count  = 0;
      burst_left   = 0;
      task_cnt     = '0;
      cur_valid    = 1'b0;
      cur_task     = '0;
      cur_slot     = '0;
      for (int t = 0; t < MAX_TASKS; t++) begin
         task_age[t]     = '0;
         task_running[t] = 1'b0;
         slot_cnt[t]     = '0;
         for (int s = 0; s < MAX_THREADS; s++) begin
            slot_age[t][s]     = '0;
            slot_running[t][s] = 1'b0;
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_tables();
      test_single_task();
      test_threadless_rival();
      test_random_mix();
      test_full_tables();

      @(negedge clock);
      start <= 1'b0;
      // every owed word in, then a tick's worth of quiet for strays
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
